// File: hw/rtl/crc_pkt_pkg.sv
// ----------------------------------------------------------------------------
// crc_pkt_pkg: shared types, codes and CRC function
// Phase and status codes, transaction structs and the X-25 byte fold used by
// the packet deframer.
// ----------------------------------------------------------------------------
package crc_pkt_pkg;

    localparam int PhaseW  = 3;
    localparam int StatusW = 2;

    localparam logic [PhaseW-1:0] PH_CMD  = 3'd0;
    localparam logic [PhaseW-1:0] PH_LEN  = 3'd1;
    localparam logic [PhaseW-1:0] PH_DATA = 3'd2;
    localparam logic [PhaseW-1:0] PH_CRCL = 3'd3;
    localparam logic [PhaseW-1:0] PH_CRCH = 3'd4;

    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_CRC_ERR = 2'd1;
    localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd2;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic      valid;
        in_item_t  item;
    } in_stage_t;

    typedef struct packed {
        logic [7:0]         data_byte;
        logic [7:0]         command;
        logic [7:0]         length;
        logic [StatusW-1:0] status;
        logic               last;
    } out_item_t;

    // Fold one byte into the reflected CRC, LSB first
    function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY_REFL : 16'h0000);
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/crc_pkt_in_if.sv
// ----------------------------------------------------------------------------
// crc_pkt_in_if: received-byte channel
// Valid/ready channel carrying the operation code and the received byte.
// ----------------------------------------------------------------------------
interface crc_pkt_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// File: hw/rtl/crc_pkt_out_if.sv
// ----------------------------------------------------------------------------
// crc_pkt_out_if: deframed result channel
// Valid/ready channel carrying payload bytes and packet end results.
// ----------------------------------------------------------------------------
interface crc_pkt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [7:0] command;
    logic [7:0] length;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output data_byte, output command, output length,
                    output status, output last, input ready);
    modport sink   (input valid, input data_byte, input command, input length,
                    input status, input last, output ready);
endinterface

// File: hw/rtl/crc_pkt_in_stage.sv
// ----------------------------------------------------------------------------
// crc_pkt_in_stage: input register
// Registers one incoming transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module crc_pkt_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  crc_pkt_pkg::in_item_t in_item,
    output logic                  in_ready,
    input  logic                  take,
    output crc_pkt_pkg::in_stage_t stage
);

    logic                  valid_reg;
    logic                  valid_next;
    crc_pkt_pkg::in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new transaction whenever the register is free
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

// File: hw/rtl/crc_pkt_parser.sv
// ----------------------------------------------------------------------------
// crc_pkt_parser: packet state, CRC check and result register
// Steps the framing state on each registered transaction, folds bytes into
// the X-25 CRC and registers payload bytes and end results for output.
// ----------------------------------------------------------------------------
module crc_pkt_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  crc_pkt_pkg::in_stage_t stage,
    output logic                   take,
    output logic                   out_valid,
    input  logic                   out_ready,
    output crc_pkt_pkg::out_item_t out_item
);

    logic [crc_pkt_pkg::PhaseW-1:0] phase_reg;
    logic [crc_pkt_pkg::PhaseW-1:0] phase_next;
    logic [7:0]                     command_reg;
    logic [7:0]                     command_next;
    logic [7:0]                     length_reg;
    logic [7:0]                     length_next;
    logic [7:0]                     count_reg;
    logic [7:0]                     count_next;
    logic [15:0]                    crc_reg;
    logic [15:0]                    crc_next;
    logic [7:0]                     crc_low_reg;
    logic [7:0]                     crc_low_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    crc_pkt_pkg::out_item_t         out_item_reg;
    crc_pkt_pkg::out_item_t         out_item_next;

    logic        out_free;
    logic        produce;
    logic [7:0]  b;
    logic [15:0] crc_base;
    logic [15:0] crc_folded;
    logic [7:0]  count_inc;
    logic [15:0] crc_rx;

    assign out_free   = !out_valid_reg || out_ready;
    assign take       = stage.valid && out_free;
    assign b          = stage.item.rx_byte;
    assign crc_base   = (phase_reg == crc_pkt_pkg::PH_LEN || phase_reg == crc_pkt_pkg::PH_DATA)
                        ? crc_reg : crc_pkt_pkg::CRC_INIT;
    assign crc_folded = crc_pkt_pkg::crc_fold(crc_base, b);
    assign count_inc  = count_reg + 8'd1;
    assign crc_rx     = {b, crc_low_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        command_next  = command_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        crc_next      = crc_reg;
        crc_low_next  = crc_low_reg;
        produce       = 1'b0;
        out_item_next = '{data_byte: 8'h00, command: command_reg, length: length_reg,
                          status: crc_pkt_pkg::ST_OK, last: 1'b0};
        if (take)
        begin
            if (stage.item.op == crc_pkt_pkg::OP_TIMEOUT)
            begin
                // Abort a packet in progress; ignore when waiting for a command
                if (phase_reg != crc_pkt_pkg::PH_CMD && phase_reg <= crc_pkt_pkg::PH_CRCH)
                begin
                    produce              = 1'b1;
                    out_item_next.status = crc_pkt_pkg::ST_TIMEOUT;
                    out_item_next.last   = 1'b1;
                end
                phase_next = crc_pkt_pkg::PH_CMD;
            end
            else
            begin
                unique case (phase_reg)
                    crc_pkt_pkg::PH_LEN:
                    begin
                        length_next = b;
                        count_next  = 8'h00;
                        crc_next    = crc_folded;
                        phase_next  = (b == 8'h00) ? crc_pkt_pkg::PH_CRCL : crc_pkt_pkg::PH_DATA;
                    end
                    crc_pkt_pkg::PH_DATA:
                    begin
                        crc_next   = crc_folded;
                        count_next = count_inc;
                        if (count_inc == length_reg)
                        begin
                            phase_next = crc_pkt_pkg::PH_CRCL;
                        end
                        produce                 = 1'b1;
                        out_item_next.data_byte = b;
                    end
                    crc_pkt_pkg::PH_CRCL:
                    begin
                        crc_low_next = b;
                        phase_next   = crc_pkt_pkg::PH_CRCH;
                    end
                    crc_pkt_pkg::PH_CRCH:
                    begin
                        produce              = 1'b1;
                        out_item_next.last   = 1'b1;
                        out_item_next.status = (crc_rx == ~crc_reg) ? crc_pkt_pkg::ST_OK
                                                                     : crc_pkt_pkg::ST_CRC_ERR;
                        phase_next           = crc_pkt_pkg::PH_CMD;
                    end
                    default:
                    begin
                        // Command byte: restart the packet
                        command_next = b;
                        length_next  = 8'h00;
                        count_next   = 8'h00;
                        crc_next     = crc_folded;
                        phase_next   = crc_pkt_pkg::PH_LEN;
                    end
                endcase
            end
        end
        if (take)
        begin
            out_valid_next = produce;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= crc_pkt_pkg::PH_CMD;
            command_reg   <= 8'h00;
            length_reg    <= 8'h00;
            count_reg     <= 8'h00;
            crc_reg       <= crc_pkt_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            command_reg   <= command_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_low_reg <= crc_low_next;
        if (take && produce)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= crc_pkt_pkg::PH_CRCH)
        else $error("phase left the legal range");

    a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_item_reg.last) |-> (out_item_reg.status == crc_pkt_pkg::ST_OK))
        else $error("payload result carries a non-ok status");

    a_end_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.last) |-> (out_item_reg.data_byte == 8'h00))
        else $error("end result carries a data byte");

    a_cmd_to_len: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stage.item.op == crc_pkt_pkg::OP_BYTE && phase_reg == crc_pkt_pkg::PH_CMD)
        |=> (phase_reg == crc_pkt_pkg::PH_LEN && !out_valid_reg))
        else $error("command byte did not advance to length");

    a_timeout_result: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stage.item.op == crc_pkt_pkg::OP_TIMEOUT && phase_reg != crc_pkt_pkg::PH_CMD)
        |=> (out_valid_reg && out_item_reg.last
             && out_item_reg.status == crc_pkt_pkg::ST_TIMEOUT
             && phase_reg == crc_pkt_pkg::PH_CMD))
        else $error("timeout in progress gave no abort result");

endmodule

// File: hw/rtl/crc_packet_deframer.sv
// ----------------------------------------------------------------------------
// crc_packet_deframer: X-25 CRC framed packet receiver
// Input register, packet parser and result register between two channels.
// ----------------------------------------------------------------------------
// Each transaction on in_ch is a received byte (op 0) or a receive timeout
// (op 1). Packets are command, length, 0 to 255 payload bytes, then the
// CRC-16/X-25 over command, length and payload, low byte first. Every payload
// byte leaves on out_ch with last low; after the second CRC byte one result
// with last high gives command, length and status (ok or crc mismatch). A
// timeout during a packet gives a last result with status timeout; a timeout
// between packets gives nothing. The block takes one transaction per cycle
// while out_ch is not stalled; each passes from acceptance through the input
// register, then through the parser and its byte-wide CRC fold into the
// result register. in_ch.ready drops only while both registers hold a
// transaction and out_ch is stalled.
module crc_packet_deframer
(
    input  logic          clk,
    input  logic          rst_n,
    crc_pkt_in_if.sink    in_ch,
    crc_pkt_out_if.source out_ch
);

    crc_pkt_pkg::in_item_t  in_item;
    crc_pkt_pkg::in_stage_t stage;
    crc_pkt_pkg::out_item_t out_item;
    logic                   take;

    assign in_item.op      = in_ch.op;
    assign in_item.rx_byte = in_ch.rx_byte;

    crc_pkt_in_stage u_in_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_item  (in_item),
        .in_ready (in_ch.ready),
        .take     (take),
        .stage    (stage)
    );

    crc_pkt_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_item)
    );

    assign out_ch.data_byte = out_item.data_byte;
    assign out_ch.command   = out_item.command;
    assign out_ch.length    = out_item.length;
    assign out_ch.status    = out_item.status;
    assign out_ch.last      = out_item.last;

endmodule
